@@ hw/rtl/drp_pkg.sv @@
// shared constants, types and tables for the driven pendulum rk4 stepper
package drp_pkg;

  localparam int CORDIC_ITERS_DEF = 24;
  localparam int ATAN_COUNT       = 30;
  localparam int CIDX_W           = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int WRAP_W      = 42;
  localparam int WRAP_STEPS  = 13;
  localparam int WRAP_CNT_W  = 4;
  localparam int REM_W       = 27;

  localparam logic signed [31:0] PI_Q      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd26353589;
  // two pi scaled by 2^(WRAP_STEPS-1)
  localparam logic [WRAP_W-1:0]  TWO_PI_TOP = 42'd431777206272;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_SQ       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_AMP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FREQ     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_VELOCITY = 3'd6;

  localparam logic [30:0]        RST_OMEGA_SQ    = 31'd16777216;
  localparam logic [30:0]        RST_DAMPING     = 31'd8388608;
  localparam logic signed [31:0] RST_DRIVE_AMP   = 32'sd15099494;
  localparam logic [30:0]        RST_DRIVE_FREQ  = 31'd11184811;
  localparam logic [30:0]        RST_STEP_SIZE   = 31'd1581129;
  localparam logic signed [26:0] RST_START_ANGLE = 27'sd26353589;

  typedef enum logic [4:0] {
    OP_NOP, OP_RST_LOAD, OP_RST_ANGLE, OP_MUL_INC, OP_CAP_INC,
    OP_WRAP_PH, OP_CAP_PH, OP_WRAP_PF, OP_CAP_PF, OP_STAGE_INIT,
    OP_SIN, OP_CAP_S, OP_COS, OP_CAP_C, OP_MUL_W, OP_CAP_T1,
    OP_MUL_D, OP_CAP_T2, OP_MUL_A, OP_CAP_ACC, OP_MUL_KA, OP_CAP_KA,
    OP_MUL_KV, OP_CAP_KV, OP_NEXT, OP_CAP_XS, OP_DIV, OP_FIN_V, OP_FIN_X
  } drp_op_t;

  typedef struct packed {
    drp_op_t    op;
    logic [1:0] stage;
  } drp_cmd_t;

  typedef struct packed {
    logic wrap_done;
    logic cordic_done;
    logic div_done;
    logic busy;
  } drp_sts_t;

  // arctan(2^-i) in q2.30
  function automatic logic [29:0] atan_q30(input logic [CIDX_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/drp_cordic.sv @@
// iterative rotation-mode cordic giving sine and cosine in q8.24
module drp_cordic #(
  parameter int CORDIC_ITERS = drp_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o,
  output logic               busy_o,
  output logic               done_o
);

  logic signed [33:0] x_r, y_r, z_r;
  logic signed [33:0] x_nxt, y_nxt, z_nxt;
  logic               neg_r, neg_nxt;
  logic [drp_pkg::CIDX_W-1:0] idx_r;
  logic               busy_r, done_r;
  logic signed [31:0] fold;
  logic signed [33:0] xs, ys, at, xo, yo;
  logic               last;

  assign last = (idx_r == drp_pkg::CIDX_W'(CORDIC_ITERS - 1));

  always_comb begin
    fold    = angle_i;
    neg_nxt = 1'b0;
    if (angle_i > drp_pkg::HALF_PI_Q) begin
      fold    = angle_i - drp_pkg::PI_Q;
      neg_nxt = 1'b1;
    end else if (angle_i < -drp_pkg::HALF_PI_Q) begin
      fold    = angle_i + drp_pkg::PI_Q;
      neg_nxt = 1'b1;
    end
    xs = x_r >>> idx_r;
    ys = y_r >>> idx_r;
    at = signed'(34'(drp_pkg::atan_q30(idx_r)));
    if (start_i) begin
      x_nxt = drp_pkg::CORDIC_GAIN;
      y_nxt = '0;
      z_nxt = 34'(fold) <<< 6;
    end else if (!z_r[33]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= neg_nxt;
    end
    if (start_i || busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign xo     = x_r >>> 6;
  assign yo     = y_r >>> 6;
  assign sin_o  = neg_r ? 32'(-yo) : 32'(yo);
  assign cos_o  = neg_r ? 32'(-xo) : 32'(xo);
  assign busy_o = busy_r;
  assign done_o = done_r;

endmodule

@@ hw/rtl/drp_wrap.sv @@
// iterative reduction modulo two pi, one compare and subtract per cycle
module drp_wrap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic signed [drp_pkg::WRAP_W-1:0] val_i,
  output logic [drp_pkg::REM_W-1:0]         rem_o,
  output logic                              busy_o,
  output logic                              done_o
);

  logic [drp_pkg::WRAP_W-1:0]     r_r, m_r;
  logic [drp_pkg::WRAP_CNT_W-1:0] cnt_r;
  logic                           busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == drp_pkg::WRAP_CNT_W'(drp_pkg::WRAP_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // scaled modulus shifts down one place per step
  always_ff @(posedge clk) begin
    if (start_i) begin
      r_r <= val_i[drp_pkg::WRAP_W-1] ? unsigned'(val_i) + drp_pkg::TWO_PI_TOP
                                      : unsigned'(val_i);
      m_r <= drp_pkg::TWO_PI_TOP;
    end else if (busy_r) begin
      if (r_r >= m_r) begin
        r_r <= r_r - m_r;
      end
      m_r <= m_r >> 1;
    end
  end

  assign rem_o  = r_r[drp_pkg::REM_W-1:0];
  assign busy_o = busy_r;
  assign done_o = done_r;

endmodule

@@ hw/rtl/drp_dp.sv @@
// datapath: registers, shared multiplier, divide by six, cordic and wrap units
module drp_dp #(
  parameter int CORDIC_ITERS = drp_pkg::CORDIC_ITERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [drp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  drp_pkg::drp_cmd_t                  cmd_i,
  output drp_pkg::drp_sts_t                  sts_o,
  output logic signed [26:0]                 out_angle,
  output logic signed [31:0]                 out_velocity,
  output logic [31:0]                        out_step_index
);

  localparam int DW = 35;
  // ceil(2^23 / 6), exact floor quotient for operands below 2^20
  localparam logic [20:0] DIV6_MUL = 21'd1398102;

  logic [30:0]        omega_r, damp_r, freq_r, dt_r;
  logic signed [31:0] amp_r, svel_r;
  logic signed [26:0] sang_r;

  logic signed [31:0] angle_r, vel_r, phase_r;
  logic [31:0]        count_r;

  logic [37:0]        incsh_r;
  logic signed [31:0] ph_r, pf_r, xs_r, vs_r, ps_r;
  logic signed [31:0] s_r, c_r, t1_r, t2_r, acc_r, ka_r, kv_r;
  logic signed [DW-1:0] suma_r, sumv_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] ma, mb;

  logic [DW-1:0] da_mag_r, dv_mag_r;
  logic [2:0]    da_rem_r, dv_rem_r;
  logic [18:0]   da_hi_r, dv_hi_r;
  logic          da_neg_r, dv_neg_r;
  logic          div_cnt_r;
  logic          div_busy_r, div_done_r;
  logic [19:0]   da_x, dv_x, da_q6, dv_q6, da_r6, dv_r6;
  logic [17:0]   da_q, dv_q;

  logic signed [26:0] out_angle_r;
  logic signed [31:0] out_vel_r;
  logic [31:0]        out_idx_r;

  logic signed [31:0] mulq_v, wang, kapart, kvpart, vnew, cor_sin, cor_cos, cor_in;
  logic signed [41:0] wrap_in, inc_full_s, inc_half_s, acc_sum;
  logic signed [35:0] qa, qv;
  logic [drp_pkg::REM_W-1:0] wrap_rem;
  logic wrap_start, wrap_busy, wrap_done, cor_start, cor_busy, cor_done, weight2;
  drp_pkg::drp_op_t op;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [17:0] div6_q(input logic [19:0] x);
    logic [40:0] p;
    p = x * DIV6_MUL;
    return p[40:23];
  endfunction

  assign op         = cmd_i.op;
  assign weight2    = (cmd_i.stage == 2'd1) || (cmd_i.stage == 2'd2);
  assign mulq_v     = sat32(prod_r[65:24]);
  assign wang       = signed'(32'(wrap_rem)) - drp_pkg::PI_Q;
  assign inc_full_s = signed'(42'(incsh_r));
  assign inc_half_s = signed'(42'(incsh_r[37:1]));
  assign kapart     = (cmd_i.stage == 2'd2) ? ka_r : (ka_r >>> 1);
  assign kvpart     = (cmd_i.stage == 2'd2) ? kv_r : (kv_r >>> 1);
  assign qa         = da_neg_r ? -signed'({1'b0, da_mag_r}) : signed'({1'b0, da_mag_r});
  assign qv         = dv_neg_r ? -signed'({1'b0, dv_mag_r}) : signed'({1'b0, dv_mag_r});
  assign vnew       = sat32(42'(vel_r) + 42'(qv));
  assign acc_sum    = 42'(mulq_v) - 42'(t1_r) - 42'(t2_r);

  always_comb begin
    case (op)
      drp_pkg::OP_MUL_INC: begin ma = {2'b0, freq_r};  mb = {2'b0, dt_r}; end
      drp_pkg::OP_MUL_W:   begin ma = {2'b0, omega_r}; mb = 33'(s_r);     end
      drp_pkg::OP_MUL_D:   begin ma = {2'b0, damp_r};  mb = 33'(vs_r);    end
      drp_pkg::OP_MUL_A:   begin ma = 33'(amp_r);      mb = 33'(c_r);     end
      drp_pkg::OP_MUL_KA:  begin ma = 33'(vs_r);       mb = {2'b0, dt_r}; end
      drp_pkg::OP_MUL_KV:  begin ma = 33'(acc_r);      mb = {2'b0, dt_r}; end
      default:             begin ma = '0;              mb = '0;           end
    endcase
  end

  always_comb begin
    wrap_start = 1'b1;
    case (op)
      drp_pkg::OP_RST_LOAD: wrap_in = 42'(sang_r) + 42'(drp_pkg::PI_Q);
      drp_pkg::OP_WRAP_PH:  wrap_in = 42'(phase_r) + inc_half_s + 42'(drp_pkg::PI_Q);
      drp_pkg::OP_WRAP_PF:  wrap_in = 42'(phase_r) + inc_full_s + 42'(drp_pkg::PI_Q);
      drp_pkg::OP_NEXT:     wrap_in = 42'(angle_r) + 42'(kapart) + 42'(drp_pkg::PI_Q);
      drp_pkg::OP_FIN_V:    wrap_in = 42'(angle_r) + 42'(qa) + 42'(drp_pkg::PI_Q);
      default: begin
        wrap_in    = '0;
        wrap_start = 1'b0;
      end
    endcase
  end

  assign cor_start = (op == drp_pkg::OP_SIN) || (op == drp_pkg::OP_COS);
  assign cor_in    = (op == drp_pkg::OP_COS) ? ps_r : xs_r;

  drp_wrap u_wrap (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (wrap_start),
    .val_i   (wrap_in),
    .rem_o   (wrap_rem),
    .busy_o  (wrap_busy),
    .done_o  (wrap_done)
  );

  drp_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cor_start),
    .angle_i (cor_in),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos),
    .busy_o  (cor_busy),
    .done_o  (cor_done)
  );

  // configuration, architectural state and divider control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r    <= drp_pkg::RST_OMEGA_SQ;
      damp_r     <= drp_pkg::RST_DAMPING;
      amp_r      <= drp_pkg::RST_DRIVE_AMP;
      freq_r     <= drp_pkg::RST_DRIVE_FREQ;
      dt_r       <= drp_pkg::RST_STEP_SIZE;
      sang_r     <= drp_pkg::RST_START_ANGLE;
      svel_r     <= '0;
      angle_r    <= 32'(drp_pkg::RST_START_ANGLE);
      vel_r      <= '0;
      phase_r    <= '0;
      count_r    <= '0;
      div_cnt_r  <= 1'b0;
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          drp_pkg::REG_OMEGA_SQ:       omega_r <= cfg_data[30:0];
          drp_pkg::REG_DAMPING:        damp_r  <= cfg_data[30:0];
          drp_pkg::REG_DRIVE_AMP:      amp_r   <= signed'(cfg_data);
          drp_pkg::REG_DRIVE_FREQ:     freq_r  <= cfg_data[30:0];
          drp_pkg::REG_STEP_SIZE:      dt_r    <= cfg_data[30:0];
          drp_pkg::REG_START_ANGLE:    sang_r  <= signed'(cfg_data[26:0]);
          drp_pkg::REG_START_VELOCITY: svel_r  <= signed'(cfg_data);
          default: ;
        endcase
      end
      case (op)
        drp_pkg::OP_RST_LOAD: begin
          vel_r   <= svel_r;
          phase_r <= '0;
          count_r <= '0;
        end
        drp_pkg::OP_RST_ANGLE: angle_r <= wang;
        drp_pkg::OP_FIN_X: begin
          angle_r <= wang;
          vel_r   <= vnew;
          phase_r <= pf_r;
          count_r <= count_r + 1'b1;
        end
        default: ;
      endcase
      if (op == drp_pkg::OP_DIV) begin
        div_cnt_r  <= 1'b0;
        div_busy_r <= 1'b1;
        div_done_r <= 1'b0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == 1'b1) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end
    end
  end

  // divide by six in two digits, the 19-bit upper digit first, then the 16-bit lower digit, by reciprocal multiply
  assign da_x  = div_cnt_r ? {1'b0, da_rem_r, da_mag_r[15:0]} : {1'b0, da_mag_r[DW-1:16]};
  assign dv_x  = div_cnt_r ? {1'b0, dv_rem_r, dv_mag_r[15:0]} : {1'b0, dv_mag_r[DW-1:16]};
  assign da_q  = div6_q(da_x);
  assign dv_q  = div6_q(dv_x);
  assign da_q6 = {da_q, 2'b00} + {1'b0, da_q, 1'b0};
  assign dv_q6 = {dv_q, 2'b00} + {1'b0, dv_q, 1'b0};
  assign da_r6 = da_x - da_q6;
  assign dv_r6 = dv_x - dv_q6;

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (op)
      drp_pkg::OP_CAP_INC: incsh_r <= prod_r[61:24];
      drp_pkg::OP_CAP_PH:  ph_r <= wang;
      drp_pkg::OP_CAP_PF:  pf_r <= wang;
      drp_pkg::OP_STAGE_INIT: begin
        xs_r   <= angle_r;
        vs_r   <= vel_r;
        ps_r   <= phase_r;
        suma_r <= '0;
        sumv_r <= '0;
      end
      drp_pkg::OP_CAP_S:   s_r  <= cor_sin;
      drp_pkg::OP_CAP_C:   c_r  <= cor_cos;
      drp_pkg::OP_CAP_T1:  t1_r <= mulq_v;
      drp_pkg::OP_CAP_T2:  t2_r <= mulq_v;
      drp_pkg::OP_CAP_ACC: acc_r <= sat32(acc_sum);
      drp_pkg::OP_CAP_KA: begin
        ka_r   <= mulq_v;
        suma_r <= suma_r + (weight2 ? (DW'(mulq_v) <<< 1) : DW'(mulq_v));
      end
      drp_pkg::OP_CAP_KV: begin
        kv_r   <= mulq_v;
        sumv_r <= sumv_r + (weight2 ? (DW'(mulq_v) <<< 1) : DW'(mulq_v));
      end
      drp_pkg::OP_NEXT: begin
        vs_r <= sat32(42'(vel_r) + 42'(kvpart));
        ps_r <= (cmd_i.stage == 2'd2) ? pf_r : ph_r;
      end
      drp_pkg::OP_CAP_XS: xs_r <= wang;
      drp_pkg::OP_FIN_X: begin
        out_angle_r <= wang[26:0];
        out_vel_r   <= vnew;
        out_idx_r   <= count_r + 1'b1;
      end
      default: ;
    endcase
    if (op == drp_pkg::OP_DIV) begin
      da_neg_r <= suma_r[DW-1];
      dv_neg_r <= sumv_r[DW-1];
      da_mag_r <= suma_r[DW-1] ? unsigned'(-suma_r) : unsigned'(suma_r);
      dv_mag_r <= sumv_r[DW-1] ? unsigned'(-sumv_r) : unsigned'(sumv_r);
      da_rem_r <= '0;
      dv_rem_r <= '0;
    end else if (div_busy_r) begin
      if (!div_cnt_r) begin
        da_hi_r  <= {1'b0, da_q};
        dv_hi_r  <= {1'b0, dv_q};
        da_rem_r <= da_r6[2:0];
        dv_rem_r <= dv_r6[2:0];
      end else begin
        da_mag_r <= {da_hi_r, da_q[15:0]};
        dv_mag_r <= {dv_hi_r, dv_q[15:0]};
      end
    end
  end

  assign sts_o.wrap_done   = wrap_done;
  assign sts_o.cordic_done = cor_done;
  assign sts_o.div_done    = div_done_r;
  assign sts_o.busy        = wrap_busy | cor_busy | div_busy_r;

  assign out_angle      = out_angle_r;
  assign out_velocity   = out_vel_r;
  assign out_step_index = out_idx_r;

endmodule

@@ hw/rtl/drp_ctrl.sv @@
// sequencer that walks the datapath through one rk4 step per input beat
module drp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output drp_pkg::drp_cmd_t cmd_o,
  input  drp_pkg::drp_sts_t sts_i
);

  typedef enum logic [5:0] {
    S_IDLE, S_RST_LOAD, S_RST_WAIT, S_RST_ANGLE, S_MUL_INC, S_CAP_INC,
    S_WRAP_PH, S_PH_WAIT, S_CAP_PH, S_WRAP_PF, S_PF_WAIT, S_CAP_PF,
    S_STAGE_INIT, S_SIN, S_SIN_WAIT, S_CAP_S, S_COS, S_COS_WAIT, S_CAP_C,
    S_MUL_W, S_CAP_T1, S_MUL_D, S_CAP_T2, S_MUL_A, S_CAP_ACC,
    S_MUL_KA, S_CAP_KA, S_MUL_KV, S_CAP_KV, S_NEXT, S_NEXT_WAIT, S_CAP_XS,
    S_DIV, S_DIV_WAIT, S_FIN_V, S_FIN_WAIT, S_FIN_X
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  drp_pkg::drp_op_t op;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r && out_stall;
    op            = drp_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_restart ? S_RST_LOAD : S_MUL_INC;
        end
      end
      S_RST_LOAD:  begin op = drp_pkg::OP_RST_LOAD; state_nxt = S_RST_WAIT; end
      S_RST_WAIT:  if (sts_i.wrap_done) state_nxt = S_RST_ANGLE;
      S_RST_ANGLE: begin op = drp_pkg::OP_RST_ANGLE; state_nxt = S_MUL_INC; end
      S_MUL_INC:   begin op = drp_pkg::OP_MUL_INC; state_nxt = S_CAP_INC; end
      S_CAP_INC:   begin op = drp_pkg::OP_CAP_INC; state_nxt = S_WRAP_PH; end
      S_WRAP_PH:   begin op = drp_pkg::OP_WRAP_PH; state_nxt = S_PH_WAIT; end
      S_PH_WAIT:   if (sts_i.wrap_done) state_nxt = S_CAP_PH;
      S_CAP_PH:    begin op = drp_pkg::OP_CAP_PH; state_nxt = S_WRAP_PF; end
      S_WRAP_PF:   begin op = drp_pkg::OP_WRAP_PF; state_nxt = S_PF_WAIT; end
      S_PF_WAIT:   if (sts_i.wrap_done) state_nxt = S_CAP_PF;
      S_CAP_PF:    begin op = drp_pkg::OP_CAP_PF; state_nxt = S_STAGE_INIT; end
      S_STAGE_INIT: begin
        op        = drp_pkg::OP_STAGE_INIT;
        stage_nxt = 2'd0;
        state_nxt = S_SIN;
      end
      S_SIN:       begin op = drp_pkg::OP_SIN; state_nxt = S_SIN_WAIT; end
      S_SIN_WAIT:  if (sts_i.cordic_done) state_nxt = S_CAP_S;
      S_CAP_S:     begin op = drp_pkg::OP_CAP_S; state_nxt = S_COS; end
      S_COS:       begin op = drp_pkg::OP_COS; state_nxt = S_COS_WAIT; end
      S_COS_WAIT:  if (sts_i.cordic_done) state_nxt = S_CAP_C;
      S_CAP_C:     begin op = drp_pkg::OP_CAP_C; state_nxt = S_MUL_W; end
      S_MUL_W:     begin op = drp_pkg::OP_MUL_W; state_nxt = S_CAP_T1; end
      S_CAP_T1:    begin op = drp_pkg::OP_CAP_T1; state_nxt = S_MUL_D; end
      S_MUL_D:     begin op = drp_pkg::OP_MUL_D; state_nxt = S_CAP_T2; end
      S_CAP_T2:    begin op = drp_pkg::OP_CAP_T2; state_nxt = S_MUL_A; end
      S_MUL_A:     begin op = drp_pkg::OP_MUL_A; state_nxt = S_CAP_ACC; end
      S_CAP_ACC:   begin op = drp_pkg::OP_CAP_ACC; state_nxt = S_MUL_KA; end
      S_MUL_KA:    begin op = drp_pkg::OP_MUL_KA; state_nxt = S_CAP_KA; end
      S_CAP_KA:    begin op = drp_pkg::OP_CAP_KA; state_nxt = S_MUL_KV; end
      S_MUL_KV:    begin op = drp_pkg::OP_MUL_KV; state_nxt = S_CAP_KV; end
      S_CAP_KV: begin
        op        = drp_pkg::OP_CAP_KV;
        state_nxt = (stage_r == 2'd3) ? S_DIV : S_NEXT;
      end
      S_NEXT:      begin op = drp_pkg::OP_NEXT; state_nxt = S_NEXT_WAIT; end
      S_NEXT_WAIT: if (sts_i.wrap_done) state_nxt = S_CAP_XS;
      S_CAP_XS: begin
        op        = drp_pkg::OP_CAP_XS;
        stage_nxt = stage_r + 1'b1;
        state_nxt = S_SIN;
      end
      S_DIV:       begin op = drp_pkg::OP_DIV; state_nxt = S_DIV_WAIT; end
      S_DIV_WAIT:  if (sts_i.div_done) state_nxt = S_FIN_V;
      S_FIN_V:     begin op = drp_pkg::OP_FIN_V; state_nxt = S_FIN_WAIT; end
      S_FIN_WAIT:  if (sts_i.wrap_done) state_nxt = S_FIN_X;
      S_FIN_X: begin
        // commit only once the output register is free
        if (slot_free) begin
          op            = drp_pkg::OP_FIN_X;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd_o.op    = op;
  assign cmd_o.stage = stage_r;

endmodule

@@ hw/rtl/driven_pendulum_rk4_step.sv @@
// Driven, damped pendulum advanced by one fourth-order Runge-Kutta step per input
// beat, velocity signed Q8.24, angle signed Q3.24 wrapped to [-pi,pi), velocity
// saturated. One item is worked at a time, using eight CORDIC runs, modulo-two-pi
// reductions for every wrapped angle and phase, a divide by six and a single
// shared multiplier. A finished result sits in an output register, so the next
// beat is taken while that result still waits on out_stall.
module driven_pendulum_rk4_step #(
  parameter int CORDIC_ITERS = drp_pkg::CORDIC_ITERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [26:0]             out_angle,
  output logic signed [31:0]             out_velocity,
  output logic [31:0]                    out_step_index
);

  drp_pkg::drp_cmd_t cmd;
  drp_pkg::drp_sts_t sts;

  drp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  drp_dp #(.CORDIC_ITERS(CORDIC_ITERS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_angle      (out_angle),
    .out_velocity   (out_velocity),
    .out_step_index (out_step_index)
  );

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted beat did not start the sequencer");

  // iterative units run only while an item is in flight
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> in_stall)
    else $error("arithmetic unit busy while sequencer idle");

  // a result appears only as an item completes
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without an item in flight");

endmodule
